// ----- rtl/vmf_pkg.sv -----
// Shared types and constants for the varint message framer.
// No dependencies; every other file of the block imports this package.
package vmf_pkg;

	localparam int HEADER_BYTES      = 7;
	localparam int POSITION_BITS_DEF = 16;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int ID_W     = 16;
	localparam int VER_W    = 16;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 16;
	localparam int PLEN_W   = 16;
	localparam int CAP_W    = 16;
	localparam int LEFT_W   = 16;
	localparam int LEN_W    = 24;
	localparam int MAG_W    = VALUE_W - 6;

	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd2048;
	localparam logic             REG_CAPACITY = 1'b0;

	localparam logic [KIND_W-1:0] KIND_INT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_VARINT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REF    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STRH   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_END    = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INT,
		ST_SFIT,
		ST_BYTE,
		ST_VAR,
		ST_HDR
	} st_t;

endpackage

// ----- rtl/vmf_ifs.sv -----
// Valid/ready channel interfaces for input items and result bytes.
// Depends on vmf_pkg for field widths.
interface vmf_item_if;
	import vmf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;
	logic signed [VALUE_W-1:0] second_value;
	logic                      null_string;
	logic [ID_W-1:0]           packet_id;
	logic [VER_W-1:0]          version;

	modport source (output valid, kind, value, second_value, null_string, packet_id, version,
		input ready);
	modport sink (input valid, kind, value, second_value, null_string, packet_id, version,
		output ready);
endinterface

interface vmf_result_if;
	import vmf_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [POS_W-1:0]  position;
	logic              dropped;
	logic              last;
	logic [PLEN_W-1:0] packet_length;

	modport source (output valid, out_byte, position, dropped, last, packet_length,
		input ready);
	modport sink (input valid, out_byte, position, dropped, last, packet_length,
		output ready);
endinterface

// ----- rtl/vmf_apb_regs.sv -----
// APB register file of the framer: holds the capacity register.
// Depends on vmf_pkg.
module vmf_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vmf_pkg::APB_AW-1:0]  paddr,
	input  logic [vmf_pkg::APB_DW-1:0]  pwdata,
	output logic [vmf_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [vmf_pkg::CAP_W-1:0]   capacity
);
	import vmf_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             hit;

	assign hit      = paddr[APB_AW-1] == REG_CAPACITY;
	assign pready   = 1'b1;
	assign prdata   = hit ? APB_DW'(cap_q) : '0;
	assign capacity = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

endmodule

// ----- rtl/vmf_room.sv -----
// Shared capacity check: write position plus byte count against capacity.
// Depends on vmf_pkg.
module vmf_room #(
	parameter int PW = vmf_pkg::POSITION_BITS_DEF
) (
	input  logic [PW-1:0]               wp,
	input  logic [vmf_pkg::VALUE_W-1:0] addend,
	input  logic [vmf_pkg::CAP_W-1:0]   capacity,
	output logic                        fit
);
	import vmf_pkg::*;

	logic [VALUE_W:0] sum;

	assign sum = (VALUE_W+1)'(wp) + (VALUE_W+1)'(addend);
	assign fit = sum <= (VALUE_W+1)'(capacity);

endmodule

// ----- rtl/varint_message_framer.sv -----
// Varint message framer: one byte per cycle from a registered result stage, while
// the result channel is not stalled. Items are taken only in the idle state, so a new
// item waits until every result byte of the last one has been emitted; the single
// output byte register and the shared capacity check set the byte rate. After the
// item transfer, the item's state loads the first result into the output register.
// Reset (arst_n low, asynchronous): position 7, capacity 2048, no string pending.
module varint_message_framer #(
	parameter int POSITION_BITS = vmf_pkg::POSITION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	vmf_item_if.sink                    item,
	vmf_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vmf_pkg::APB_AW-1:0]  paddr,
	input  logic [vmf_pkg::APB_DW-1:0]  pwdata,
	output logic [vmf_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import vmf_pkg::*;

	localparam int PW = POSITION_BITS;

	st_t                state_q, state_d;
	logic [PW-1:0]      wp_q, wp_d;
	logic               fits_q, fits_d;
	logic [LEFT_W-1:0]  left_q, left_d;
	logic               ok_q, ok_d;
	logic [2:0]         idx_q, idx_d;
	logic [55:0]        sh_q, sh_d;
	logic [VALUE_W-1:0] va_q, va_d;
	logic [MAG_W-1:0]   mag_q, mag_d;
	logic               vfirst_q, vfirst_d;
	logic [VALUE_W-1:0] sec_q, sec_d;
	logic               refp_q, refp_d;
	logic               smode_q, smode_d;
	logic               snull_q, snull_d;
	logic               bchk_q, bchk_d;

	logic               ov_q;
	logic [BYTE_W-1:0]  ob_q;
	logic [POS_W-1:0]   op_q;
	logic               od_q, ol_q;
	logic [PLEN_W-1:0]  opl_q;

	logic               emit, e_drop, e_last;
	logic [BYTE_W-1:0]  e_byte;
	logic [POS_W-1:0]   e_pos;
	logic [PLEN_W-1:0]  e_plen;

	logic               adv, fit, ok;
	logic [VALUE_W-1:0] addend;
	logic [CAP_W-1:0]   capacity;
	logic [LEN_W-1:0]   len24;
	logic [MAG_W-1:0]   magn;
	logic [BYTE_W-1:0]  vbyte;
	logic               more;

	vmf_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	vmf_room #(.PW(PW)) u_room (
		.wp       (wp_q),
		.addend   (addend),
		.capacity (capacity),
		.fit      (fit)
	);

	assign adv   = !ov_q || result.ready;
	assign len24 = LEN_W'(wp_q) - LEN_W'(HEADER_BYTES);
	assign magn  = mag_q >> 7;

	always_comb begin
		case (state_q)
			ST_IDLE: addend = VALUE_W'(4);
			ST_SFIT: addend = sec_q;
			default: addend = VALUE_W'(1);
		endcase
	end

	always_comb begin
		if (vfirst_q) begin
			vbyte = {mag_q != '0, va_q[VALUE_W-1], va_q[5:0]};
			more  = mag_q != '0;
		end else begin
			vbyte = {magn != '0, va_q[6:0]};
			more  = magn != '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		wp_d     = wp_q;
		fits_d   = fits_q;
		left_d   = left_q;
		ok_d     = ok_q;
		idx_d    = idx_q;
		sh_d     = sh_q;
		va_d     = va_q;
		mag_d    = mag_q;
		vfirst_d = vfirst_q;
		sec_d    = sec_q;
		refp_d   = refp_q;
		smode_d  = smode_q;
		snull_d  = snull_q;
		bchk_d   = bchk_q;
		emit     = 1'b0;
		e_byte   = '0;
		e_pos    = '0;
		e_drop   = 1'b0;
		e_last   = 1'b0;
		e_plen   = '0;
		ok       = 1'b0;
		item.ready = 1'b0;

		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					idx_d    = '0;
					va_d     = item.value;
					mag_d    = MAG_W'((item.value ^ {VALUE_W{item.value[VALUE_W-1]}}) >> 6);
					vfirst_d = 1'b1;
					refp_d   = 1'b0;
					sec_d    = item.second_value;
					ok_d     = fit;
					smode_d  = 1'b0;
					snull_d  = item.null_string;
					bchk_d   = 1'b1;
					sh_d     = {item.value, 24'd0};
					case (item.kind)
						KIND_INT:    state_d = ST_INT;
						KIND_BYTE:   state_d = ST_BYTE;
						KIND_VARINT: state_d = ST_VAR;
						KIND_REF: begin
							refp_d  = item.value != '0;
							state_d = ST_VAR;
						end
						KIND_STRH: begin
							smode_d = 1'b1;
							sec_d   = item.value;
							if (item.null_string) begin
								sh_d = {{VALUE_W{1'b1}}, 24'd0};
							end
							state_d = ST_INT;
						end
						KIND_CHAR: begin
							if (left_q != '0) begin
								left_d  = left_q - 1'b1;
								bchk_d  = 1'b0;
								state_d = ST_BYTE;
							end
						end
						KIND_END: begin
							sh_d    = {item.packet_id, len24, item.version};
							state_d = ST_HDR;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INT: begin
				if (adv) begin
					emit   = 1'b1;
					e_byte = ok_q ? sh_q[55:48] : '0;
					e_pos  = POS_W'(wp_q + (ok_q ? PW'(0) : PW'(idx_q)));
					e_drop = !ok_q;
					if (ok_q) begin
						wp_d = wp_q + 1'b1;
					end
					sh_d  = sh_q << 8;
					idx_d = idx_q + 1'b1;
					if (idx_q == 3'd3) begin
						e_last  = 1'b1;
						state_d = smode_q ? ST_SFIT : ST_IDLE;
					end
				end
			end
			ST_SFIT: begin
				if (snull_q) begin
					fits_d = 1'b0;
					left_d = '0;
				end else if (sec_q[VALUE_W-1]) begin
					fits_d = 1'b1;
					left_d = '0;
				end else begin
					fits_d = fit;
					left_d = (sec_q[VALUE_W-2:LEFT_W] != '0) ? '1 : sec_q[LEFT_W-1:0];
				end
				state_d = ST_IDLE;
			end
			ST_BYTE: begin
				if (adv) begin
					ok     = bchk_q ? fit : fits_q;
					emit   = 1'b1;
					e_byte = ok ? va_q[BYTE_W-1:0] : '0;
					e_pos  = POS_W'(wp_q);
					e_drop = !ok;
					e_last = 1'b1;
					if (ok) begin
						wp_d = wp_q + 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_VAR: begin
				if (adv) begin
					ok     = fit;
					emit   = 1'b1;
					e_byte = ok ? vbyte : '0;
					e_pos  = POS_W'(wp_q);
					e_drop = !ok;
					if (ok) begin
						wp_d = wp_q + 1'b1;
					end
					vfirst_d = 1'b0;
					if (vfirst_q) begin
						va_d = {{6{va_q[VALUE_W-1]}}, va_q[VALUE_W-1:6]};
					end else begin
						va_d  = {{7{va_q[VALUE_W-1]}}, va_q[VALUE_W-1:7]};
						mag_d = magn;
					end
					if (!more) begin
						if (refp_q) begin
							refp_d   = 1'b0;
							vfirst_d = 1'b1;
							va_d     = sec_q;
							mag_d    = MAG_W'((sec_q ^ {VALUE_W{sec_q[VALUE_W-1]}}) >> 6);
						end else begin
							e_last  = 1'b1;
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_HDR: begin
				if (adv) begin
					emit   = 1'b1;
					e_byte = sh_q[55:48];
					e_pos  = POS_W'(idx_q);
					sh_d   = sh_q << 8;
					idx_d  = idx_q + 1'b1;
					if (idx_q == 3'(HEADER_BYTES - 1)) begin
						e_last  = 1'b1;
						e_plen  = PLEN_W'(wp_q);
						wp_d    = PW'(HEADER_BYTES);
						fits_d  = 1'b0;
						left_d  = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= PW'(HEADER_BYTES);
			fits_q  <= 1'b0;
			left_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			fits_q  <= fits_d;
			left_q  <= left_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_q     <= ok_d;
		idx_q    <= idx_d;
		sh_q     <= sh_d;
		va_q     <= va_d;
		mag_q    <= mag_d;
		vfirst_q <= vfirst_d;
		sec_q    <= sec_d;
		refp_q   <= refp_d;
		smode_q  <= smode_d;
		snull_q  <= snull_d;
		bchk_q   <= bchk_d;
		if (emit) begin
			ob_q  <= e_byte;
			op_q  <= e_pos;
			od_q  <= e_drop;
			ol_q  <= e_last;
			opl_q <= e_plen;
		end
	end

	assign result.valid         = ov_q;
	assign result.out_byte      = ob_q;
	assign result.position      = op_q;
	assign result.dropped       = od_q;
	assign result.last          = ol_q;
	assign result.packet_length = opl_q;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && od_q) |-> (ob_q == '0 && opl_q == '0))
		else $error("dropped byte carries data");

	a_plen_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && opl_q != '0) |-> (ol_q && op_q == POS_W'(HEADER_BYTES - 1)))
		else $error("packet length off the last header byte");

	a_end_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind == KIND_END) |=> (state_q == ST_HDR))
		else $error("end item did not start header");

	a_wp_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HDR && adv && idx_q == 3'(HEADER_BYTES - 1))
		|=> (wp_q == PW'(HEADER_BYTES) && left_q == '0 && !fits_q))
		else $error("position not rewound after header");

endmodule

// ----- bench/framer_check_pkg.sv -----
`timescale 1ns / 100ps
// Transfer types and the byte-stream scoreboard for the varint message framer bench.
// Depends on vmf_pkg for widths and field kinds.
package framer_check_pkg;
	import vmf_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] second_value;
		logic               null_string;
		logic [ID_W-1:0]    packet_id;
		logic [VER_W-1:0]   version;
	} field_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [POS_W-1:0]  position;
		logic              dropped;
		logic              last;
		logic [PLEN_W-1:0] packet_length;
	} frame_byte_t;

	class frame_byte_checker;
		logic [CAP_W-1:0]  capacity;
		logic [POS_W-1:0]  wr_pos;
		logic              body_fits;
		logic [LEFT_W-1:0] chars_left;
		frame_byte_t       expected_bytes[$];
		int                mismatches;

		function new();
			capacity   = CAP_RESET;
			wr_pos     = POS_W'(HEADER_BYTES);
			body_fits  = 1'b0;
			chars_left = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void log_mismatch(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("MISMATCH: %s", msg);
		endfunction

		function void push_byte(logic [7:0] b, logic [POS_W-1:0] pos, logic drop,
				logic [PLEN_W-1:0] plen);
			frame_byte_t e;
			e.out_byte      = drop ? 8'h00 : b;
			e.position      = pos;
			e.dropped       = drop;
			e.last          = 1'b0;
			e.packet_length = plen;
			expected_bytes.push_back(e);
		endfunction

		function logic fits_bytes(logic [31:0] n);
			return ({48'b0, wr_pos} + {32'b0, n}) <= {48'b0, capacity};
		endfunction

		function void put_word(logic [31:0] v);
			logic ok;
			ok = fits_bytes(32'd4);
			for (int i = 0; i < 4; i++) begin
				if (ok) begin
					push_byte(v[31 - 8*i -: 8], wr_pos, 1'b0, '0);
					wr_pos = wr_pos + 1'b1;
				end else begin
					push_byte(8'h00, wr_pos + POS_W'(i), 1'b1, '0);
				end
			end
		endfunction

		function void put_single(logic [7:0] b);
			if (fits_bytes(32'd1)) begin
				push_byte(b, wr_pos, 1'b0, '0);
				wr_pos = wr_pos + 1'b1;
			end else begin
				push_byte(8'h00, wr_pos, 1'b1, '0);
			end
		endfunction

		function void put_varint(logic [31:0] v);
			logic signed [31:0] a;
			logic [31:0]        mag;
			logic [7:0]         head;
			int                 n;
			a    = v;
			head = {1'b0, a[31], a[5:0]};
			mag  = (a ^ {32{a[31]}}) >> 6;
			a    = a >>> 6;
			if (mag == 0) begin
				put_single(head);
			end else begin
				put_single(head | 8'h80);
				mag = mag >> 7;
				put_single({mag != 0, a[6:0]});
				a = a >>> 7;
				n = 2;
				while (mag != 0 && n < 5) begin
					mag = mag >> 7;
					put_single({mag != 0, a[6:0]});
					a = a >>> 7;
					n++;
				end
			end
		endfunction

		function void note_field(field_item_t it);
			int          n_queued;
			logic [23:0] len;
			frame_byte_t tail;
			n_queued = expected_bytes.size();
			case (it.kind)
				KIND_INT: put_word(it.value);
				KIND_BYTE: put_single(it.value[7:0]);
				KIND_VARINT: put_varint(it.value);
				KIND_REF: begin
					put_varint(it.value);
					if (it.value != 0)
						put_varint(it.second_value);
				end
				KIND_STRH: begin
					if (it.null_string) begin
						put_word(32'hFFFF_FFFF);
						body_fits  = 1'b0;
						chars_left = '0;
					end else begin
						put_word(it.value);
						if (it.value[31]) begin
							body_fits  = 1'b1;
							chars_left = '0;
						end else begin
							body_fits  = fits_bytes(it.value);
							chars_left = (it.value > 32'hFFFF) ? 16'hFFFF : it.value[15:0];
						end
					end
				end
				KIND_CHAR: begin
					if (chars_left != 0) begin
						chars_left = chars_left - 1'b1;
						if (body_fits) begin
							push_byte(it.value[7:0], wr_pos, 1'b0, '0);
							wr_pos = wr_pos + 1'b1;
						end else begin
							push_byte(8'h00, wr_pos, 1'b1, '0);
						end
					end
				end
				KIND_END: begin
					len = {8'b0, wr_pos} - 24'(HEADER_BYTES);
					push_byte(it.packet_id[15:8], 16'd0, 1'b0, '0);
					push_byte(it.packet_id[7:0], 16'd1, 1'b0, '0);
					push_byte(len[23:16], 16'd2, 1'b0, '0);
					push_byte(len[15:8], 16'd3, 1'b0, '0);
					push_byte(len[7:0], 16'd4, 1'b0, '0);
					push_byte(it.version[15:8], 16'd5, 1'b0, '0);
					push_byte(it.version[7:0], 16'd6, 1'b0, wr_pos);
					wr_pos     = POS_W'(HEADER_BYTES);
					body_fits  = 1'b0;
					chars_left = '0;
				end
				default: ;
			endcase
			if (expected_bytes.size() > n_queued) begin
				tail = expected_bytes.pop_back();
				tail.last = 1'b1;
				expected_bytes.push_back(tail);
			end
		endfunction

		function void check_byte(frame_byte_t got);
			frame_byte_t want;
			if (expected_bytes.size() == 0) begin
				log_mismatch($sformatf("unexpected byte %h at position %0d",
					got.out_byte, got.position));
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.position !== want.position ||
					got.dropped !== want.dropped || got.last !== want.last ||
					got.packet_length !== want.packet_length)
				log_mismatch({
					$sformatf("expected byte %h pos %0d drop %b last %b plen %0d",
						want.out_byte, want.position, want.dropped, want.last,
						want.packet_length),
					$sformatf(", got byte %h pos %0d drop %b last %b plen %0d",
						got.out_byte, got.position, got.dropped, got.last,
						got.packet_length)});
		endfunction
	endclass

endpackage

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Top-level bench for varint_message_framer: drives field items and the APB port,
// and checks every result byte. Depends on vmf_pkg, vmf_ifs and framer_check_pkg.
module testbench;
	import vmf_pkg::*;
	import framer_check_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int fields_sent = 0;

	frame_byte_checker sb;

	vmf_item_if   item_ch();
	vmf_result_if result_ch();

	varint_message_framer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		frame_byte_t got;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ch.ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.out_byte      = result_ch.out_byte;
				got.position      = result_ch.position;
				got.dropped       = result_ch.dropped;
				got.last          = result_ch.last;
				got.packet_length = result_ch.packet_length;
				sb.check_byte(got);
			end
		end
	end

	function automatic field_item_t field(logic [KIND_W-1:0] kind, logic [31:0] value);
		field_item_t f;
		f.kind         = kind;
		f.value        = value;
		f.second_value = $urandom;
		f.null_string  = (kind == KIND_STRH) ? 1'b0 : 1'($urandom);
		f.packet_id    = 16'($urandom);
		f.version      = 16'($urandom);
		return f;
	endfunction

	function automatic logic [31:0] rand_varint();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	// call just after a falling edge; returns just after a falling edge
	task automatic send_item(input field_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= it.kind;
		item_ch.value        <= it.value;
		item_ch.second_value <= it.second_value;
		item_ch.null_string  <= it.null_string;
		item_ch.packet_id    <= it.packet_id;
		item_ch.version      <= it.version;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		sb.note_field(it);
		if (it.kind != KIND_UNUSED)
			fields_sent++;
		@(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		logic [APB_DW-1:0] rd;
		logic [APB_AW-1:0] addr;
		addr = APB_AW'({REG_CAPACITY, 2'b00});
		apb_xfer(1'b1, addr, {16'b0, cap}, rd);
		sb.capacity = cap;
		apb_xfer(1'b0, addr, '0, rd);
		if (rd !== {16'b0, cap})
			sb.log_mismatch($sformatf("capacity readback expected %h, got %h", cap, rd));
	endtask

	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_message(input int n_fields);
		field_item_t f;
		int          r;
		int          nchars;
		for (int i = 0; i < n_fields; i++) begin
			r = $urandom_range(99);
			if (r < 20) begin
				send_item(field(KIND_INT, $urandom));
			end else if (r < 35) begin
				send_item(field(KIND_BYTE, $urandom));
			end else if (r < 58) begin
				send_item(field(KIND_VARINT, rand_varint()));
			end else if (r < 72) begin
				f = field(KIND_REF, ($urandom_range(3) == 0) ? 32'd0 : rand_varint());
				f.second_value = rand_varint();
				send_item(f);
			end else if (r < 92) begin
				f = field(KIND_STRH, $urandom_range(0, 8));
				r = $urandom_range(99);
				if (r < 10)
					f.null_string = 1'b1;
				else if (r < 16)
					f.value = 32'h8000_0000 | $urandom;
				else if (r < 21)
					f.value = $urandom_range(65536, 32'h7FFF_FFFF);
				nchars = (!f.null_string && f.value <= 8) ? int'(f.value) : $urandom_range(0, 3);
				if ($urandom_range(9) == 0)
					nchars++;
				send_item(f);
				for (int c = 0; c < nchars; c++) begin
					if ($urandom_range(7) == 0)
						send_item(field(KIND_VARINT, rand_varint()));
					send_item(field(KIND_CHAR, $urandom));
				end
			end else if (r < 96) begin
				send_item(field(KIND_UNUSED, $urandom));
			end else begin
				send_item(field(KIND_CHAR, $urandom));
			end
		end
		send_item(field(KIND_END, $urandom));
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
			input int stall_pct, input int hold, input int n_fields);
		write_capacity(cap);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		hold_cycles    = hold;
		fields_sent    = 0;
		while (fields_sent < n_fields)
			send_message($urandom_range(1, 6));
		item_ch.valid <= 1'b0;
		wait_idle();
	endtask

	initial begin
		field_item_t f;
		sb = new();
		item_ch.valid        = 1'b0;
		item_ch.kind         = '0;
		item_ch.value        = '0;
		item_ch.second_value = '0;
		item_ch.null_string  = 1'b0;
		item_ch.packet_id    = '0;
		item_ch.version      = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset capacity, field extremes and string corner cases
		send_item(field(KIND_INT, 32'h8000_0000));
		send_item(field(KIND_INT, 32'h7FFF_FFFF));
		send_item(field(KIND_BYTE, 32'h1234_56FF));
		send_item(field(KIND_VARINT, 32'd0));
		send_item(field(KIND_VARINT, 32'hFFFF_FFFF));
		send_item(field(KIND_VARINT, 32'd64));
		send_item(field(KIND_VARINT, 32'hFFFF_FFBF));
		send_item(field(KIND_VARINT, 32'h7FFF_FFFF));
		f = field(KIND_REF, 32'd0);
		f.second_value = 32'h7FFF_FFFF;
		send_item(f);
		f = field(KIND_REF, 32'h8000_0000);
		f.second_value = 32'hFFFF_FFFF;
		send_item(f);
		send_item(field(KIND_STRH, 32'd2));
		send_item(field(KIND_CHAR, 32'h41));
		send_item(field(KIND_CHAR, 32'hFFFF_FF42));
		send_item(field(KIND_CHAR, 32'h43));
		f = field(KIND_STRH, 32'd3);
		f.null_string = 1'b1;
		send_item(f);
		send_item(field(KIND_STRH, 32'hFFFF_FFFB));
		send_item(field(KIND_STRH, 32'd70000));
		send_item(field(KIND_CHAR, 32'h44));
		send_item(field(KIND_UNUSED, 32'hFFFF_FFFF));
		f = field(KIND_END, 32'd0);
		f.packet_id = 16'hFFFF;
		f.version   = 16'h0000;
		send_item(f);
		item_ch.valid <= 1'b0;
		wait_idle();

		// tight capacity: body accepted, then written past the limit
		write_capacity(16'd20);
		send_item(field(KIND_STRH, 32'd4));
		send_item(field(KIND_INT, $urandom));
		send_item(field(KIND_INT, $urandom));
		send_item(field(KIND_INT, $urandom));
		for (int c = 0; c < 4; c++)
			send_item(field(KIND_CHAR, $urandom));
		f = field(KIND_END, 32'd0);
		f.packet_id = 16'h0000;
		f.version   = 16'hFFFF;
		send_item(f);
		item_ch.valid <= 1'b0;
		wait_idle();

		run_phase(16'd2048, 0, 0, 0, 75);
		run_phase(16'd40, 63, 0, 0, 55);
		run_phase(16'd7, 0, 63, 0, 35);
		run_phase(16'($urandom_range(7, 300)), 6, 6, 0, 65);
		run_phase(16'd65535, 0, 0, 500, 75);

		recv_stall_pct = 0;
		for (int n = 0; n < 100000 && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.pending() != 0)
			sb.log_mismatch($sformatf("%0d expected bytes never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
